// File: rtl/hsmts_pkg.sv
package hsmts_pkg;

  localparam int NUM_STATES_DEF = 16;
  localparam int MAX_DEPTH_DEF  = 8;
  localparam int NODE_W         = 4;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TRANS = 2'd2;

  localparam logic [1:0] ACT_EXIT  = 2'd0;
  localparam logic [1:0] ACT_ENTER = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  localparam logic [NODE_W-1:0] ROOT_INDEX = '0;

  typedef struct packed {
    logic [1:0]        operation;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;
    logic              has_parent;
  } in_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [NODE_W-1:0] action_node;
    logic              error;
    logic              last;
  } out_t;

  // one parent table word: root mark above the parent index
  typedef struct packed {
    logic              root;
    logic [NODE_W-1:0] parent;
  } entry_t;

endpackage

// File: rtl/hsmts_parent_ram.sv
module hsmts_parent_ram #(
  parameter int NUM_STATES = hsmts_pkg::NUM_STATES_DEF
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(NUM_STATES)-1:0]  waddr_i,
  input  hsmts_pkg::entry_t              wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(NUM_STATES)-1:0]  raddr_i,
  output hsmts_pkg::entry_t              rdata_o
);
  import hsmts_pkg::*;

  entry_t mem [NUM_STATES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hsm_transition_sequencer_core.sv
// hierarchical state machine transition sequencer
//
// input channel (in_valid_i / in_ready_o / in_data_i): one beat per request.
//   load writes one parent table word and gives no result beats; start and
//   transition give a run of exit / enter / initial beats on the output
//   channel (out_valid_o / out_ready_i / out_data_o), last set on the final one.
// a refused request (broken chain, transition before start) gives a single
//   error beat and leaves the current state untouched.
// each ancestor step is a parent table read, then a check of the word read;
//   a transition walks the current chain and usually the target chain, then
//   emits one beat per cycle while the receiver is ready. one request is worked
//   at a time; in_ready_o rises again once the last beat is in the output
//   register.
// the common-ancestor search runs alongside the target walk: each new target
//   node is compared against the stored current chain above its first entry at once.
// reset clears the current state and the started flag; the parent table is
//   undefined until loaded.
// a stalled receiver simply holds the output register; sequencing waits.
module hsm_transition_sequencer_core #(
  parameter int NUM_STATES = hsmts_pkg::NUM_STATES_DEF,
  parameter int MAX_DEPTH  = hsmts_pkg::MAX_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsmts_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsmts_pkg::out_t   out_data_o
);
  import hsmts_pkg::*;

  localparam int AW = $clog2(NUM_STATES);
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int IW = $clog2(MAX_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_EXIT  = 3'd3;
  localparam logic [2:0] S_ENTER = 3'd4;
  localparam logic [2:0] S_INIT  = 3'd5;
  localparam logic [2:0] S_ERR   = 3'd6;

  logic [2:0] state_q, state_d;

  // architectural state
  logic [NODE_W-1:0] cur_state_q, cur_state_d;
  logic              started_q, started_d;

  // request being worked
  logic [1:0]        op_q, op_d;
  logic [NODE_W-1:0] node_q, node_d;

  // chain walk
  logic [NODE_W-1:0] idx_q, idx_d;
  logic [DW-1:0]     widx_q, widx_d;
  logic              walk_tgt_q, walk_tgt_d;
  logic [DW-1:0]     clen_q, clen_d;

  // hits collected during the walks
  logic              ahit_q, ahit_d;
  logic [DW-1:0]     ahit_idx_q, ahit_idx_d;
  logic              cshit_q, cshit_d;
  logic [DW-1:0]     cshit_idx_q, cshit_idx_d;
  logic              ca_q, ca_d;
  logic [DW-1:0]     ca_i_q, ca_i_d;
  logic [DW-1:0]     ca_j_q, ca_j_d;

  // emission
  logic [DW-1:0]     ex_cnt_q, ex_cnt_d;
  logic [DW-1:0]     ex_k_q, ex_k_d;
  logic [DW-1:0]     en_k_q, en_k_d;
  logic              init_q, init_d;

  // chain stores
  logic [NODE_W-1:0] cur_chain [MAX_DEPTH];
  logic [NODE_W-1:0] tgt_chain [MAX_DEPTH];
  logic              cur_we, tgt_we;
  logic [IW-1:0]     cur_wi, tgt_wi;
  logic [NODE_W-1:0] cur_wd, tgt_wd;

  // parent table port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata, ram_rdata;

  // output register
  logic              out_valid_q;
  out_t              out_data_q;
  logic              out_load;
  out_t              out_beat;
  logic              out_free;

  logic              in_fire;
  logic              idx_ok;
  logic              node_ok;
  logic [DW-1:0]     len;
  logic              cmatch;
  logic [DW-1:0]     cmatch_j;

  hsmts_parent_ram #(
    .NUM_STATES(NUM_STATES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign idx_ok     = (32'(idx_q) < NUM_STATES);
  assign node_ok    = (32'(in_data_i.node) < NUM_STATES);
  assign len        = widx_q + DW'(1);

  assign ram_waddr  = AW'(in_data_i.node);
  assign ram_wdata  = '{root: !in_data_i.has_parent, parent: in_data_i.parent};

  // lowest position of the current chain (above its first entry) that holds idx
  always_comb begin
    cmatch   = 1'b0;
    cmatch_j = '0;
    for (int j = MAX_DEPTH - 1; j >= 1; j--) begin
      if ((DW'(j) < clen_q) && (cur_chain[j] == idx_q)) begin
        cmatch   = 1'b1;
        cmatch_j = DW'(j);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_state_d = cur_state_q;
    started_d   = started_q;
    op_d        = op_q;
    node_d      = node_q;
    idx_d       = idx_q;
    widx_d      = widx_q;
    walk_tgt_d  = walk_tgt_q;
    clen_d      = clen_q;
    ahit_d      = ahit_q;
    ahit_idx_d  = ahit_idx_q;
    cshit_d     = cshit_q;
    cshit_idx_d = cshit_idx_q;
    ca_d        = ca_q;
    ca_i_d      = ca_i_q;
    ca_j_d      = ca_j_q;
    ex_cnt_d    = ex_cnt_q;
    ex_k_d      = ex_k_q;
    en_k_d      = en_k_q;
    init_d      = init_q;
    cur_we      = 1'b0;
    cur_wi      = '0;
    cur_wd      = node_q;
    tgt_we      = 1'b0;
    tgt_wi      = '0;
    tgt_wd      = node_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_load    = 1'b0;
    out_beat    = '{action: ACT_EXIT, action_node: node_q, error: 1'b0, last: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = in_data_i.operation;
          node_d  = in_data_i.node;
          widx_d  = '0;
          ahit_d  = 1'b0;
          cshit_d = 1'b0;
          ca_d    = 1'b0;
          ex_k_d  = '0;
          unique case (in_data_i.operation)
            OP_LOAD: begin
              ram_we = node_ok;
            end
            OP_START: begin
              idx_d      = in_data_i.node;
              walk_tgt_d = 1'b1;
              state_d    = S_RD;
            end
            OP_TRANS: begin
              if (!started_q) begin
                state_d = S_ERR;
              end else if (in_data_i.node == cur_state_q) begin
                // leaf restart: exit and re-enter, no initial
                cur_we   = 1'b1;
                cur_wd   = in_data_i.node;
                tgt_we   = 1'b1;
                tgt_wd   = in_data_i.node;
                ex_cnt_d = DW'(1);
                en_k_d   = '0;
                init_d   = 1'b0;
                state_d  = S_EXIT;
              end else begin
                idx_d      = cur_state_q;
                walk_tgt_d = 1'b0;
                state_d    = S_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        if (!idx_ok) begin
          state_d = S_ERR;
        end else begin
          ram_re = 1'b1;
          if (walk_tgt_q) begin
            tgt_we = 1'b1;
            tgt_wi = widx_q[IW-1:0];
            tgt_wd = idx_q;
            if (widx_q != '0) begin
              if (!cshit_q && idx_q == cur_state_q) begin
                cshit_d     = 1'b1;
                cshit_idx_d = widx_q;
              end
              if (!ca_q && cmatch) begin
                ca_d   = 1'b1;
                ca_i_d = widx_q;
                ca_j_d = cmatch_j;
              end
            end
          end else begin
            cur_we = 1'b1;
            cur_wi = widx_q[IW-1:0];
            cur_wd = idx_q;
            if (widx_q != '0 && !ahit_q && idx_q == node_q) begin
              ahit_d     = 1'b1;
              ahit_idx_d = widx_q;
            end
          end
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        if (ram_rdata.root) begin
          init_d = 1'b1;
          ex_k_d = '0;
          if (!walk_tgt_q) begin
            if (node_q == ROOT_INDEX || ahit_q) begin
              // root or ancestor restart: exit up to it, enter it, run initial
              tgt_we      = 1'b1;
              ex_cnt_d    = (node_q == ROOT_INDEX) ? len : ahit_idx_q + DW'(1);
              en_k_d      = '0;
              cur_state_d = node_q;
              state_d     = S_EXIT;
            end else begin
              clen_d     = len;
              idx_d      = node_q;
              widx_d     = '0;
              walk_tgt_d = 1'b1;
              state_d    = S_RD;
            end
          end else begin
            cur_state_d = node_q;
            if (op_q == OP_START) begin
              started_d = 1'b1;
              en_k_d    = widx_q;
              state_d   = S_ENTER;
            end else if (cshit_q) begin
              // initial descent from the current state
              en_k_d  = cshit_idx_q - DW'(1);
              state_d = S_ENTER;
            end else if (ca_q) begin
              ex_cnt_d = ca_j_q;
              en_k_d   = ca_i_q - DW'(1);
              state_d  = S_EXIT;
            end else begin
              // disjoint chains: leave everything, enter from the root
              ex_cnt_d = clen_q;
              en_k_d   = widx_q;
              state_d  = S_EXIT;
            end
          end
        end else if (widx_q == DW'(MAX_DEPTH - 1)) begin
          state_d = S_ERR;
        end else begin
          idx_d   = ram_rdata.parent;
          widx_d  = len;
          state_d = S_RD;
        end
      end

      S_EXIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_beat = '{action: ACT_EXIT, action_node: cur_chain[ex_k_q[IW-1:0]],
                       error: 1'b0, last: 1'b0};
          ex_k_d   = ex_k_q + DW'(1);
          if (ex_k_q + DW'(1) == ex_cnt_q) begin
            state_d = S_ENTER;
          end
        end
      end

      S_ENTER: begin
        if (out_free) begin
          out_load = 1'b1;
          out_beat = '{action: ACT_ENTER, action_node: tgt_chain[en_k_q[IW-1:0]],
                       error: 1'b0, last: (en_k_q == '0) && !init_q};
          if (en_k_q == '0) begin
            state_d = init_q ? S_INIT : S_IDLE;
          end else begin
            en_k_d = en_k_q - DW'(1);
          end
        end
      end

      S_INIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_beat = '{action: ACT_INIT, action_node: node_q, error: 1'b0, last: 1'b1};
          state_d  = S_IDLE;
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          out_beat = '{action: ACT_EXIT, action_node: node_q, error: 1'b1, last: 1'b1};
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_state_q <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_state_q <= cur_state_d;
      started_q   <= started_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    node_q      <= node_d;
    idx_q       <= idx_d;
    widx_q      <= widx_d;
    walk_tgt_q  <= walk_tgt_d;
    clen_q      <= clen_d;
    ahit_q      <= ahit_d;
    ahit_idx_q  <= ahit_idx_d;
    cshit_q     <= cshit_d;
    cshit_idx_q <= cshit_idx_d;
    ca_q        <= ca_d;
    ca_i_q      <= ca_i_d;
    ca_j_q      <= ca_j_d;
    ex_cnt_q    <= ex_cnt_d;
    ex_k_q      <= ex_k_d;
    en_k_q      <= en_k_d;
    init_q      <= init_d;
    if (cur_we) begin
      cur_chain[cur_wi] <= cur_wd;
    end
    if (tgt_we) begin
      tgt_chain[tgt_wi] <= tgt_wd;
    end
    if (out_load) begin
      out_data_q <= out_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // an error beat always closes its request
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.last)
    else $error("error beat without last");

  // exits are only sequenced once the machine has been started
  a_exit_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXIT |-> started_q)
    else $error("exit sequenced before start");

  // walk position stays inside the chain store
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> widx_q < DW'(MAX_DEPTH))
    else $error("walk beyond depth bound");

  // a beat is never loaded over one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hsmts_pkg::*;

  localparam int NSTATES    = NUM_STATES_DEF;
  localparam int DEPTH      = MAX_DEPTH_DEF;
  localparam int TAIL_WAIT  = 80;
  localparam int CYCLE_CAP  = 600000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [NODE_W-1:0] chain_t [DEPTH];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // shadow of the block: parent table, root marks, current state
  logic [NODE_W-1:0] shadow_parent [NSTATES];
  logic              shadow_root   [NSTATES];
  logic [NODE_W-1:0] shadow_cur;
  logic              shadow_started;

  out_t action_queue[$];     // beats still owed by the block
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   snd_idle = 0;        // sender idle chance, percent
  int   rcv_idle = 0;        // receiver idle chance, percent
  int   hold_cnt = 0;        // receiver hold-off, cycles left

  always #1 clk_i = ~clk_i;

  hsm_transition_sequencer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // ancestor walk; 0 means no root within the depth bound
  function automatic int walk_up(input logic [NODE_W-1:0] from, output chain_t lst);
    logic [NODE_W-1:0] idx;
    idx = from;
    lst = '{default: '0};
    for (int i = 0; i < DEPTH; i++) begin
      lst[i] = idx;
      if (shadow_root[idx]) return i + 1;
      idx = shadow_parent[idx];
    end
    return 0;
  endfunction

  function automatic void owe(input logic [1:0] act, input logic [NODE_W-1:0] nd);
    out_t b;
    b.action = act;
    b.action_node = nd;
    b.error = 1'b0;
    b.last = 1'b0;
    action_queue.push_back(b);
  endfunction

  function automatic void owe_refusal(input logic [NODE_W-1:0] nd);
    out_t b;
    b.action = ACT_EXIT;
    b.action_node = nd;
    b.error = 1'b1;
    b.last = 1'b1;
    action_queue.push_back(b);
  endfunction

  // works out the beats one request causes and updates the shadow state
  function automatic void sequence_request(input in_t it);
    chain_t cur, tgt;
    int clen, tlen, base, tl, cl;
    bit found;
    logic [NODE_W-1:0] nd;
    nd = it.node;
    base = action_queue.size();
    if (it.operation == OP_LOAD) begin
      shadow_parent[nd] = it.parent;
      shadow_root[nd] = !it.has_parent;
      return;
    end
    if (it.operation == OP_START) begin
      tlen = walk_up(nd, tgt);
      if (tlen == 0) begin
        owe_refusal(nd);
        return;
      end
      for (int i = tlen - 1; i >= 0; i--) owe(ACT_ENTER, tgt[i]);
      shadow_cur = nd;
      shadow_started = 1'b1;
      owe(ACT_INIT, nd);
    end else if (it.operation == OP_TRANS) begin
      if (!shadow_started) begin
        owe_refusal(nd);
        return;
      end
      if (nd == shadow_cur) begin
        // leaf restart: exit and re-enter, no initial
        owe(ACT_EXIT, nd);
        owe(ACT_ENTER, nd);
      end else begin
        clen = walk_up(shadow_cur, cur);
        if (clen == 0) begin
          owe_refusal(nd);
          return;
        end
        found = 1'b0;
        if (nd == ROOT_INDEX) begin
          for (int i = 0; i < clen; i++) owe(ACT_EXIT, cur[i]);
          found = 1'b1;
        end else begin
          for (int i = 1; i < clen && !found; i++)
            if (cur[i] == nd) begin
              for (int j = 0; j <= i; j++) owe(ACT_EXIT, cur[j]);
              found = 1'b1;
            end
        end
        if (found) begin
          owe(ACT_ENTER, nd);
        end else begin
          tlen = walk_up(nd, tgt);
          if (tlen == 0) begin
            owe_refusal(nd);
            return;
          end
          // initial descent: current state sits on the target chain
          for (int i = 1; i < tlen && !found; i++)
            if (tgt[i] == shadow_cur) begin
              for (int j = i - 1; j >= 0; j--) owe(ACT_ENTER, tgt[j]);
              found = 1'b1;
            end
          if (!found) begin
            tl = tlen;
            cl = clen;
            for (int i = 1; i < tlen && !found; i++)
              for (int j = 1; j < clen && !found; j++)
                if (tgt[i] == cur[j]) begin
                  tl = i;
                  cl = j;
                  found = 1'b1;
                end
            for (int j = 0; j < cl; j++) owe(ACT_EXIT, cur[j]);
            for (int i = tl - 1; i >= 0; i--) owe(ACT_ENTER, tgt[i]);
          end
        end
        shadow_cur = nd;
        owe(ACT_INIT, nd);
      end
    end else begin
      return;
    end
    if (action_queue.size() > base) action_queue[action_queue.size() - 1].last = 1'b1;
  endfunction

  // offer one beat, wait for acceptance, then predict
  task automatic send_beat(input in_t it);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sequence_request(it);
  endtask

  function automatic in_t mk(input logic [1:0] op, input int nd, input int par = 0,
                             input bit hp = 1'b1);
    in_t it;
    it.operation = op;
    it.node = NODE_W'(nd);
    it.parent = NODE_W'(par);
    it.has_parent = hp;
    return it;
  endfunction

  // output side: ready with random gaps, compare every accepted beat
  always @(posedge clk_i) begin
    out_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (action_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %p", out_data_o));
      end else begin
        exp_b = action_queue.pop_front();
        if (out_data_o.action !== exp_b.action)
          report_mismatch($sformatf("action %0d want %0d", out_data_o.action, exp_b.action));
        if (out_data_o.action_node !== exp_b.action_node)
          report_mismatch($sformatf("node %0d want %0d", out_data_o.action_node,
                                    exp_b.action_node));
        if (out_data_o.error !== exp_b.error)
          report_mismatch($sformatf("error %b want %b", out_data_o.error, exp_b.error));
        if (out_data_o.last !== exp_b.last)
          report_mismatch($sformatf("last %b want %b", out_data_o.last, exp_b.last));
      end
    end
    out_ready_i <= (hold_cnt == 0) && ($urandom_range(99) >= rcv_idle);
  end

  // hold-off counter for the pressure test
  always @(posedge clk_i) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[hsm_transition_sequencer_core] ERROR");
      $finish;
    end
  end

  // fixed tree: 0 root, 8 second root, 14 at full depth, 15 one past it
  task automatic test_directed();
    int par_of [NSTATES] = '{0, 0, 0, 1, 1, 2, 3, 6, 0, 8, 9, 10, 7, 12, 13, 14};
    send_beat(mk(OP_TRANS, 3));                 // transition before start
    send_beat(mk(OP_UNUSED, 15, 15, 1'b1));     // unused code
    for (int n = 0; n < NSTATES; n++)
      send_beat(mk(OP_LOAD, n, par_of[n], !(n == 0 || n == 8)));
    send_beat(mk(OP_START, 15));                // broken chain
    send_beat(mk(OP_START, 7));
    send_beat(mk(OP_TRANS, 7));                 // leaf restart
    send_beat(mk(OP_TRANS, 4));                 // common ancestor
    send_beat(mk(OP_TRANS, 1));                 // ancestor restart
    send_beat(mk(OP_TRANS, 14));                // initial descent, full depth
    send_beat(mk(OP_TRANS, 0));                 // root restart
    send_beat(mk(OP_TRANS, 11));                // other tree, no common ancestor
    send_beat(mk(OP_START, 14));                // start while started
    send_beat(mk(OP_TRANS, 15));                // broken target
    send_beat(mk(OP_LOAD, 15, 15, 1'b1));       // self loop
    send_beat(mk(OP_TRANS, 15));
    send_beat(mk(OP_LOAD, 15, 15, 1'b0));       // now a root
    send_beat(mk(OP_TRANS, 15));
    send_beat(mk(OP_TRANS, 5));
  endtask

  // mostly well-formed loads (parent below node) so chains stay walkable
  task automatic test_random(input int count);
    in_t it;
    int r, nd;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      nd = $urandom_range(NSTATES - 1);
      if (r < 20) begin
        if ($urandom_range(3) != 0 && nd > 0)
          it = mk(OP_LOAD, nd, $urandom_range(nd - 1), 1'b1);
        else
          it = mk(OP_LOAD, nd, $urandom_range(NSTATES - 1), 1'($urandom_range(1)));
      end else if (r < 35) begin
        it = mk(OP_START, nd, $urandom_range(NSTATES - 1), 1'($urandom_range(1)));
      end else if (r < 96) begin
        it = mk(OP_TRANS, nd, $urandom_range(NSTATES - 1), 1'($urandom_range(1)));
      end else begin
        it = mk(OP_UNUSED, nd, $urandom_range(NSTATES - 1), 1'($urandom_range(1)));
      end
      send_beat(it);
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_cnt = 400;
    test_random(20);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    shadow_cur = '0;
    shadow_started = 1'b0;

    test_directed();
    snd_idle = 27; rcv_idle = 60;
    test_random(100);
    snd_idle = 60; rcv_idle = 27;
    test_random(100);
    snd_idle = 0; rcv_idle = 0;
    test_backpressure();
    test_random(100);

    in_valid_i <= 1'b0;
    wait (action_queue.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0)
      $display("[hsm_transition_sequencer_core] OK");
    else
      $display("[hsm_transition_sequencer_core] ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/hsmts_pkg.sv
rtl/hsmts_parent_ram.sv
rtl/hsm_transition_sequencer_core.sv
sim/tb_top.sv
